FILE: rtl/text_console_cursor_scroll_assert.svh
// assertion macros shared by the console modules
`ifndef TEXT_CONSOLE_CURSOR_SCROLL_ASSERT_SVH
`define TEXT_CONSOLE_CURSOR_SCROLL_ASSERT_SVH

// expression holds at every clock edge out of reset
`define TCCS_ASSERT_ALWAYS(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
    else $error("console check failed");

// antecedent in one cycle implies consequent in the next
`define TCCS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("console check failed");

`endif

FILE: rtl/tccs_pkg.sv
// shared types and constants of the text console
`default_nettype none

package tccs_pkg;

  localparam logic       CMD_PUT      = 1'b0;
  localparam logic       CMD_READ     = 1'b1;
  localparam logic [7:0] NEWLINE_CODE = 8'h0A;
  localparam logic [7:0] SPACE_CODE   = 8'h20;
  localparam logic [7:0] RESET_COLOR  = 8'h07;
  localparam logic [15:0] RESET_CELL  = {RESET_COLOR, SPACE_CODE};

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_RDWAIT,
    S_SCROLL,
    S_DRAIN
  } state_t;

  typedef struct packed {
    logic item_load;
    logic clear_wr;
    logic exec;
    logic scroll_step;
    logic out_load;
    logic out_scrolled;
  } cmd_t;

  typedef struct packed {
    logic is_read;
    logic need_scroll;
    logic cnt_last;
    logic out_blocked;
  } status_t;

endpackage

`default_nettype wire

FILE: rtl/text_console_cursor_scroll.sv
// top level of the text console with cursor and scroll-up
// a command is latched in IDLE and run in EXEC; a read goes on through RDWAIT, a scrolling put or
// newline through SCROLL and DRAIN; a new command is taken only in IDLE, with the output not stalled
// a scroll moves one cell per cycle through the memory read/write pair, then blanks the last row
// reset: synchronous active-low; afterwards a sweep writes grey spaces over all ROWS*COLUMNS
// cells, one per cycle, with input stalled; config writes are taken throughout
`default_nettype none

module text_console_cursor_scroll #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 24
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // register port: attribute byte for new characters
  input  wire logic        cfg_wr_en,
  input  wire logic [7:0]  cfg_wr_data,
  // command beats
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_command,
  input  wire logic [7:0]  in_char_code,
  input  wire logic [4:0]  in_read_row,
  input  wire logic [6:0]  in_read_col,
  // result beats
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      out_cell_value,
  output logic [4:0]       out_cursor_row,
  output logic [6:0]       out_cursor_col,
  output logic             out_scrolled
);

  // controller drives commands, datapath reports status back
  tccs_pkg::cmd_t    cmd;
  tccs_pkg::status_t st;

  tccs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  // holds screen memory, cursor and the result register that decouples the output side
  tccs_dp #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_command     (in_command),
    .in_char_code   (in_char_code),
    .in_read_row    (in_read_row),
    .in_read_col    (in_read_col),
    .cmd            (cmd),
    .st             (st),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_cell_value (out_cell_value),
    .out_cursor_row (out_cursor_row),
    .out_cursor_col (out_cursor_col),
    .out_scrolled   (out_scrolled)
  );

endmodule

`default_nettype wire

FILE: rtl/tccs_dp.sv
// console datapath: screen memory, cursor, sweep counter and result register
`default_nettype none
`include "text_console_cursor_scroll_assert.svh"

module tccs_dp #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 24
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            cfg_wr_en,
  input  wire logic [7:0]      cfg_wr_data,
  input  wire logic            in_command,
  input  wire logic [7:0]      in_char_code,
  input  wire logic [4:0]      in_read_row,
  input  wire logic [6:0]      in_read_col,
  input  wire tccs_pkg::cmd_t  cmd,
  output tccs_pkg::status_t    st,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output logic [15:0]          out_cell_value,
  output logic [4:0]           out_cursor_row,
  output logic [6:0]           out_cursor_col,
  output logic                 out_scrolled
);

  localparam int CELLS = ROWS * COLUMNS;
  localparam int AW    = $clog2(CELLS);
  localparam int RW    = $clog2(ROWS);
  localparam int CW    = $clog2(COLUMNS);
  localparam int PW    = 16;

  logic [15:0]   screen_mem_r [CELLS];
  logic [15:0]   rdata_r;

  logic [7:0]    text_color_r;
  logic          cmd_r;
  logic [7:0]    ch_r;
  logic [4:0]    rrow_r;
  logic [6:0]    rcol_r;
  logic          rd_ok_r;

  logic [RW-1:0] row_r, row_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic [AW-1:0] base_r, base_nxt;
  logic [AW-1:0] cnt_r;

  logic          pw_valid_r;
  logic [AW-1:0] pw_addr_r;
  logic          pw_copy_r;

  logic          out_valid_r;
  logic [15:0]   out_cell_r;
  logic [4:0]    out_row_r;
  logic [6:0]    out_col_r;
  logic          out_scr_r;

  logic          is_newline;
  logic          wrap;
  logic          put_wr;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] raddr;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [15:0]   mem_wdata;

  assign is_newline = (ch_r == tccs_pkg::NEWLINE_CODE);
  assign wrap       = is_newline || (col_r == CW'(COLUMNS - 1));
  assign put_wr     = cmd.exec && (cmd_r == tccs_pkg::CMD_PUT) && !is_newline;
  assign rd_addr    = AW'(PW'(rrow_r) * PW'(COLUMNS) + PW'(rcol_r));
  assign raddr      = cmd.scroll_step ? (cnt_r + AW'(COLUMNS)) : rd_addr;

  assign st.is_read     = (cmd_r == tccs_pkg::CMD_READ);
  assign st.need_scroll = (cmd_r == tccs_pkg::CMD_PUT) && wrap && (row_r == RW'(ROWS - 1));
  assign st.cnt_last    = (cnt_r == AW'(CELLS - 1));
  assign st.out_blocked = out_valid_r && out_stall;

  // cursor update
  always_comb begin
    row_nxt  = row_r;
    col_nxt  = col_r;
    base_nxt = base_r;
    if (cmd.exec && (cmd_r == tccs_pkg::CMD_PUT)) begin
      if (wrap) begin
        col_nxt = '0;
        if (row_r != RW'(ROWS - 1)) begin
          row_nxt  = row_r + RW'(1);
          base_nxt = base_r + AW'(COLUMNS);
        end
      end else begin
        col_nxt = col_r + CW'(1);
      end
    end
  end

  // single write port: clearing sweep, scroll pipe, or a put
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cnt_r;
    mem_wdata = tccs_pkg::RESET_CELL;
    if (cmd.clear_wr) begin
      mem_we = 1'b1;
    end else if (pw_valid_r) begin
      mem_we    = 1'b1;
      mem_waddr = pw_addr_r;
      mem_wdata = pw_copy_r ? rdata_r : {text_color_r, tccs_pkg::SPACE_CODE};
    end else if (put_wr) begin
      mem_we    = 1'b1;
      mem_waddr = base_r + AW'(col_r);
      mem_wdata = {text_color_r, ch_r};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      screen_mem_r[mem_waddr] <= mem_wdata;
    end
    rdata_r <= screen_mem_r[raddr];
  end

  // item latch, read range check, scroll pipe and result register loads
  always_ff @(posedge clk) begin
    if (cmd.item_load) begin
      cmd_r  <= in_command;
      ch_r   <= in_char_code;
      rrow_r <= in_read_row;
      rcol_r <= in_read_col;
    end
    if (cmd.exec) begin
      rd_ok_r <= (32'(rrow_r) < ROWS) && (32'(rcol_r) < COLUMNS);
    end
    if (cmd.scroll_step) begin
      pw_addr_r <= cnt_r;
      pw_copy_r <= (cnt_r < AW'(CELLS - COLUMNS));
    end
    if (cmd.out_load) begin
      out_cell_r <= (st.is_read && rd_ok_r) ? rdata_r : 16'h0000;
      out_row_r  <= 5'(row_nxt);
      out_col_r  <= 7'(col_nxt);
      out_scr_r  <= cmd.out_scrolled;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      text_color_r <= tccs_pkg::RESET_COLOR;
      row_r        <= '0;
      col_r        <= '0;
      base_r       <= '0;
      cnt_r        <= '0;
      pw_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        text_color_r <= cfg_wr_data;
      end
      row_r      <= row_nxt;
      col_r      <= col_nxt;
      base_r     <= base_nxt;
      pw_valid_r <= cmd.scroll_step;
      if (cmd.clear_wr || cmd.scroll_step) begin
        cnt_r <= st.cnt_last ? '0 : cnt_r + AW'(1);
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_cell_value = out_cell_r;
  assign out_cursor_row = out_row_r;
  assign out_cursor_col = out_col_r;
  assign out_scrolled   = out_scr_r;

  `TCCS_ASSERT_ALWAYS(a_cursor_range, clk, rst_n, (32'(row_r) < ROWS) && (32'(col_r) < COLUMNS))
  `TCCS_ASSERT_ALWAYS(a_base_match, clk, rst_n, base_r == AW'(32'(row_r) * COLUMNS))
  `TCCS_ASSERT_ALWAYS(a_load_free, clk, rst_n, !(cmd.out_load && out_valid_r))

endmodule

`default_nettype wire

FILE: rtl/tccs_ctrl.sv
// console controller: sequences clearing, commands and scroll sweeps
`default_nettype none
`include "text_console_cursor_scroll_assert.svh"

module tccs_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire tccs_pkg::status_t st,
  output tccs_pkg::cmd_t         cmd
);

  tccs_pkg::state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tccs_pkg::S_CLEAR: begin
        if (st.cnt_last) state_nxt = tccs_pkg::S_IDLE;
      end
      tccs_pkg::S_IDLE: begin
        if (in_valid && !st.out_blocked) state_nxt = tccs_pkg::S_EXEC;
      end
      tccs_pkg::S_EXEC: begin
        if (st.is_read) begin
          state_nxt = tccs_pkg::S_RDWAIT;
        end else if (st.need_scroll) begin
          state_nxt = tccs_pkg::S_SCROLL;
        end else begin
          state_nxt = tccs_pkg::S_IDLE;
        end
      end
      tccs_pkg::S_RDWAIT: state_nxt = tccs_pkg::S_IDLE;
      tccs_pkg::S_SCROLL: begin
        if (st.cnt_last) state_nxt = tccs_pkg::S_DRAIN;
      end
      tccs_pkg::S_DRAIN:  state_nxt = tccs_pkg::S_IDLE;
      default:            state_nxt = tccs_pkg::S_CLEAR;
    endcase
  end

  always_comb begin
    in_stall         = (state_r != tccs_pkg::S_IDLE) || st.out_blocked;
    cmd.item_load    = in_valid && !in_stall;
    cmd.clear_wr     = (state_r == tccs_pkg::S_CLEAR);
    cmd.exec         = (state_r == tccs_pkg::S_EXEC);
    cmd.scroll_step  = (state_r == tccs_pkg::S_SCROLL);
    cmd.out_load     = ((state_r == tccs_pkg::S_EXEC) && !st.is_read && !st.need_scroll)
                       || (state_r == tccs_pkg::S_RDWAIT) || (state_r == tccs_pkg::S_DRAIN);
    cmd.out_scrolled = (state_r == tccs_pkg::S_DRAIN);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tccs_pkg::S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  `TCCS_ASSERT_ALWAYS(a_cmd_excl, clk, rst_n, $onehot0({cmd.item_load, cmd.clear_wr, cmd.scroll_step, cmd.out_load}))
  `TCCS_ASSERT_NEXT(a_scroll_done, clk, rst_n, cmd.scroll_step && st.cnt_last, cmd.out_load && cmd.out_scrolled)
  `TCCS_ASSERT_NEXT(a_accept_exec, clk, rst_n, cmd.item_load, cmd.exec)

endmodule

`default_nettype wire

FILE: bench/tb.sv
// self-checking testbench for the text console: cursor, wrap, newline, scroll-up and cell reads
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COLUMNS = 80;
  localparam int ROWS    = 24;
  localparam int CELLS   = ROWS * COLUMNS;

  // one result beat as the block reports it
  typedef struct packed {
    logic [15:0] cell_val;
    logic [4:0]  row;
    logic [6:0]  col;
    logic        scrolled;
  } console_result_t;

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        cfg_wr_en   = 1'b0;
  logic [7:0]  cfg_wr_data = '0;
  logic        in_valid    = 1'b0;
  logic        in_stall;
  logic        in_command  = tccs_pkg::CMD_PUT;
  logic [7:0]  in_char_code = '0;
  logic [4:0]  in_read_row = '0;
  logic [6:0]  in_read_col = '0;
  logic        out_valid;
  logic        out_stall   = 1'b0;
  logic [15:0] out_cell_value;
  logic [4:0]  out_cursor_row;
  logic [6:0]  out_cursor_col;
  logic        out_scrolled;

  // shadow copy of the screen, cursor and attribute register
  logic [15:0] screen_shadow [CELLS];
  int          cursor_row_q;
  int          cursor_col_q;
  logic [7:0]  text_attr;

  console_result_t pending_results [$];
  int failures = 0;
  bit idle_on  = 1'b1;

  text_console_cursor_scroll #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_command    (in_command),
    .in_char_code  (in_char_code),
    .in_read_row   (in_read_row),
    .in_read_col   (in_read_col),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_cell_value(out_cell_value),
    .out_cursor_row(out_cursor_row),
    .out_cursor_col(out_cursor_col),
    .out_scrolled  (out_scrolled)
  );

  always #5 clk = ~clk;

  // cursor to column 0 of the next row; on the last row everything moves up
  // one row, cells keep their own attribute, and the bottom row is blanked
  // in the current attribute; returns 1 when a scroll happened
  function automatic logic advance_line();
    cursor_col_q = 0;
    if (cursor_row_q + 1 < ROWS) begin
      cursor_row_q++;
      return 1'b0;
    end
    cursor_row_q = ROWS - 1;
    for (int i = 0; i < CELLS - COLUMNS; i++) screen_shadow[i] = screen_shadow[i + COLUMNS];
    for (int c = 0; c < COLUMNS; c++)
      screen_shadow[CELLS - COLUMNS + c] = {text_attr, tccs_pkg::SPACE_CODE};
    return 1'b1;
  endfunction

  // apply one accepted command beat to the shadow and return its result beat
  function automatic console_result_t console_step(logic cmd, logic [7:0] ch,
                                                   logic [4:0] rr, logic [6:0] rc);
    console_result_t res;
    res = '0;
    if (cmd == tccs_pkg::CMD_READ) begin
      // out-of-range reads give 0 and leave everything alone
      if (int'(rr) < ROWS && int'(rc) < COLUMNS)
        res.cell_val = screen_shadow[int'(rr) * COLUMNS + int'(rc)];
    end else if (ch == tccs_pkg::NEWLINE_CODE) begin
      // newline writes no cell
      res.scrolled = advance_line();
    end else begin
      screen_shadow[cursor_row_q * COLUMNS + cursor_col_q] = {text_attr, ch};
      cursor_col_q++;
      // wrap at the line end
      if (cursor_col_q >= COLUMNS) res.scrolled = advance_line();
    end
    res.row = cursor_row_q[4:0];
    res.col = cursor_col_q[6:0];
    return res;
  endfunction

  // drive one command beat, hold it until taken, then record what it must produce
  task automatic send_command(logic cmd, logic [7:0] ch, logic [4:0] rr, logic [6:0] rc);
    in_valid     <= 1'b1;
    in_command   <= cmd;
    in_char_code <= ch;
    in_read_row  <= rr;
    in_read_col  <= rc;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(console_step(cmd, ch, rr, rc));
    // random sender gap after the beat
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
  endtask

  // hold the sender off until every outstanding result has come back
  task automatic wait_results_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // attribute register write; only issued with the block idle
  task automatic write_text_attr(logic [7:0] attr);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= attr;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    text_attr = attr;
  endtask

  // result side back-pressure in random bursts
  initial begin
    forever begin
      @(posedge clk);
      if (idle_on && $urandom_range(0, 9) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 13)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // every taken result beat against the oldest expectation
  always @(posedge clk) begin
    console_result_t exp_res;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result beat with nothing expected: cell %h row %0d col %0d scrolled %0b",
               out_cell_value, out_cursor_row, out_cursor_col, out_scrolled);
        failures++;
      end else begin
        exp_res = pending_results.pop_front();
        if (out_cell_value !== exp_res.cell_val) begin
          $error("cell_value: expected %h, actual %h", exp_res.cell_val, out_cell_value);
          failures++;
        end
        if (out_cursor_row !== exp_res.row) begin
          $error("cursor_row: expected %0d, actual %0d", exp_res.row, out_cursor_row);
          failures++;
        end
        if (out_cursor_col !== exp_res.col) begin
          $error("cursor_col: expected %0d, actual %0d", exp_res.col, out_cursor_col);
          failures++;
        end
        if (out_scrolled !== exp_res.scrolled) begin
          $error("scrolled: expected %0b, actual %0b", exp_res.scrolled, out_scrolled);
          failures++;
        end
      end
    end
  end

  // corners of a freshly cleared screen read back as grey spaces
  task automatic test_reset_contents();
    send_command(tccs_pkg::CMD_READ, 8'h00, 5'd0, 7'd0);
    send_command(tccs_pkg::CMD_READ, 8'hFF, 5'(ROWS - 1), 7'(COLUMNS - 1));
    send_command(tccs_pkg::CMD_READ, 8'h5A, 5'd0, 7'(COLUMNS - 1));
    send_command(tccs_pkg::CMD_READ, 8'hA5, 5'(ROWS - 1), 7'd0);
  endtask

  // extreme character codes at the default attribute, then read back
  task automatic test_put_extremes();
    send_command(tccs_pkg::CMD_PUT, 8'h00, 5'h1F, 7'h7F);
    send_command(tccs_pkg::CMD_PUT, 8'hFF, 5'h00, 7'h00);
    send_command(tccs_pkg::CMD_PUT, tccs_pkg::SPACE_CODE, 5'h15, 7'h2A);
    send_command(tccs_pkg::CMD_PUT, 8'h7F, 5'h0A, 7'h55);
    send_command(tccs_pkg::CMD_READ, 8'h00, 5'd0, 7'd0);
    send_command(tccs_pkg::CMD_READ, 8'h00, 5'd0, 7'd1);
  endtask

  // new characters take the written attribute, old cells keep theirs
  task automatic test_text_attr();
    wait_results_drained();
    write_text_attr(8'hFF);
    send_command(tccs_pkg::CMD_PUT, 8'h41, 5'd0, 7'd0);
    send_command(tccs_pkg::CMD_READ, 8'h00, 5'd0, 7'd4);
    wait_results_drained();
    write_text_attr(8'h00);
    send_command(tccs_pkg::CMD_PUT, 8'h42, 5'd0, 7'd0);
    send_command(tccs_pkg::CMD_READ, 8'h00, 5'd0, 7'd5);
    send_command(tccs_pkg::CMD_READ, 8'h00, 5'd0, 7'd3);
  endtask

  // newline moves to the next row and writes nothing
  task automatic test_newline();
    send_command(tccs_pkg::CMD_PUT, tccs_pkg::NEWLINE_CODE, 5'd3, 7'd9);
    send_command(tccs_pkg::CMD_PUT, tccs_pkg::NEWLINE_CODE, 5'd0, 7'd0);
    send_command(tccs_pkg::CMD_READ, 8'h00, 5'd0, 7'd6);
  endtask

  // reads past the last row or column return 0
  task automatic test_out_of_range_read();
    send_command(tccs_pkg::CMD_READ, 8'h00, 5'(ROWS), 7'd0);
    send_command(tccs_pkg::CMD_READ, 8'h00, 5'd0, 7'(COLUMNS));
    send_command(tccs_pkg::CMD_READ, 8'hFF, 5'h1F, 7'h7F);
  endtask

  // mostly printable text with occasional newlines, mixed with reads;
  // reads lean toward the cursor row and the bottom row where things change
  task automatic run_console_traffic(int beats);
    int kind;
    logic [4:0] rr;
    logic [6:0] rc;
    for (int i = 0; i < beats; i++) begin
      kind = $urandom_range(0, 99);
      rr = 5'($urandom_range(0, 31));
      rc = 7'($urandom_range(0, 127));
      if (kind < 6) begin
        send_command(tccs_pkg::CMD_PUT, tccs_pkg::NEWLINE_CODE, rr, rc);
      end else if (kind < 62) begin
        send_command(tccs_pkg::CMD_PUT, 8'($urandom_range(8'h21, 8'h7E)), rr, rc);
      end else if (kind < 72) begin
        // any byte, newline included
        send_command(tccs_pkg::CMD_PUT, 8'($urandom_range(0, 255)), rr, rc);
      end else if (kind < 94) begin
        case ($urandom_range(0, 2))
          0: rr = 5'(cursor_row_q);
          1: rr = 5'(ROWS - 1);
          default: rr = 5'($urandom_range(0, ROWS - 1));
        endcase
        rc = 7'($urandom_range(0, COLUMNS - 1));
        send_command(tccs_pkg::CMD_READ, 8'($urandom_range(0, 255)), rr, rc);
      end else begin
        if ($urandom_range(0, 1) == 0) rr = 5'($urandom_range(ROWS, 31));
        else rc = 7'($urandom_range(COLUMNS, 127));
        send_command(tccs_pkg::CMD_READ, 8'($urandom_range(0, 255)), rr, rc);
      end
    end
  endtask

  // one random phase per attribute setting, extremes included
  task automatic test_random_traffic();
    logic [7:0] attrs [5];
    attrs = '{8'h00, 8'hFF, 8'h1E, 8'($urandom_range(0, 255)), tccs_pkg::RESET_COLOR};
    foreach (attrs[k]) begin
      // the sender waits for every result before each register write
      wait_results_drained();
      write_text_attr(attrs[k]);
      run_console_traffic(330);
    end
  endtask

  // closing stretch with both sides running flat out
  task automatic test_full_rate();
    wait_results_drained();
    idle_on = 1'b0;
    write_text_attr(8'($urandom_range(0, 255)));
    run_console_traffic(250);
  endtask

  initial begin
    for (int i = 0; i < CELLS; i++) screen_shadow[i] = tccs_pkg::RESET_CELL;
    cursor_row_q = 0;
    cursor_col_q = 0;
    text_attr    = tccs_pkg::RESET_COLOR;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // the clearing sweep after reset shows up as in_stall, the sender just waits
    test_reset_contents();
    test_put_extremes();
    test_text_attr();
    test_newline();
    test_out_of_range_read();
    test_random_traffic();
    test_full_rate();

    wait_results_drained();
    // room for a stray beat after a full scroll
    repeat (CELLS + 8) @(posedge clk);

    if (failures == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // hang guard
  initial begin
    #40_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl
rtl/tccs_pkg.sv
rtl/tccs_dp.sv
rtl/tccs_ctrl.sv
rtl/text_console_cursor_scroll.sv
bench/tb.sv
